// ----- rtl/grouped_integer_to_ascii_defines.svh -----
`ifndef GROUPED_INTEGER_TO_ASCII_DEFINES_SVH
`define GROUPED_INTEGER_TO_ASCII_DEFINES_SVH

// same-cycle implication, held off while reset is high
`define GIA_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, held off while reset is high
`define GIA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/gia_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package gia_pkg;

  localparam int IN_WIDTH   = 32;
  // a 32-bit value has at most ten decimal digits
  localparam int MAX_DIGITS = 10;
  localparam int DIGIT_BITS = 4 * MAX_DIGITS;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_A     = 8'h61;
  localparam logic [7:0] CH_COMMA = 8'h2c;
  localparam logic [3:0] DIGIT_NINE = 4'd9;
  localparam logic [7:0] DIGIT_TEN  = 8'd10;

  localparam logic [1:0] DEC_GROUP_M1 = 2'd2;
  localparam logic [1:0] HEX_GROUP_M1 = 2'd3;

  typedef logic [3:0] digit_t;
  typedef digit_t [MAX_DIGITS-1:0] digits_t;
  typedef logic [3:0] dcount_t;

  typedef struct packed {
    digits_t digits;
    logic    hex;
  } conv_res_t;

  // n mod 3 for n below twelve
  function automatic logic [1:0] mod3(input dcount_t n);
    dcount_t r;
    r = n;
    if (r >= 4'd6) r = r - 4'd6;
    if (r >= 4'd3) r = r - 4'd3;
    return r[1:0];
  endfunction

  function automatic logic [7:0] digit_char(input digit_t d);
    if (d <= DIGIT_NINE) return CH_ZERO + {4'b0, d};
    else return CH_A + {4'b0, d} - DIGIT_TEN;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/gia_chan_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
interface gia_num_if import gia_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [IN_WIDTH-1:0] value;
  logic                hex_mode;
  modport source (output valid, value, hex_mode, input ready);
  modport sink   (input valid, value, hex_mode, output ready);
endinterface

interface gia_chr_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       last;
  modport source (output valid, out_char, last, input ready);
  modport sink   (input valid, out_char, last, output ready);
endinterface
`default_nettype wire

// ----- rtl/gia_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
module gia_front import gia_pkg::*; #(
  parameter int W_EFF = 32
) (
  input  logic             clk,
  input  logic             rst,
  gia_num_if.sink          num,
  output logic             q_valid,
  input  logic             q_ready,
  output logic [W_EFF-1:0] q_value,
  output logic             q_hex
);

  logic [W_EFF-1:0] value_mem [2];
  logic             hex_mem [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             push;
  logic             pop;

  assign num.ready = (count != 2'd2);
  assign push      = num.valid && num.ready;
  assign q_valid   = (count != 2'd0);
  assign pop       = q_valid && q_ready;
  assign q_value   = value_mem[rd_ptr];
  assign q_hex     = hex_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  // only the low bits of the request take part
  always_ff @(posedge clk) begin
    if (push) begin
      value_mem[wr_ptr] <= num.value[W_EFF-1:0];
      hex_mem[wr_ptr]   <= num.hex_mode;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/gia_conv.sv -----
`timescale 1ns / 1ps
`default_nettype none
module gia_conv import gia_pkg::*; #(
  parameter int W_EFF = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  output logic             q_ready,
  input  logic [W_EFF-1:0] q_value,
  input  logic             q_hex,
  output logic             res_valid,
  input  logic             res_ready,
  output conv_res_t        res
);

  localparam int NSTEP  = (W_EFF + 3) / 4;
  localparam int PAD    = NSTEP * 4;
  localparam int STEP_W = $clog2(NSTEP);

  logic                  busy;
  logic [PAD-1:0]        val;
  logic [DIGIT_BITS-1:0] bcd;
  logic [STEP_W-1:0]     step;
  logic [PAD-1:0]        val_next;
  logic [DIGIT_BITS-1:0] bcd_next;
  logic                  take;

  assign q_ready = !busy && !res_valid;
  assign take    = q_valid && q_ready;

  // four shift-and-add-3 steps per cycle
  always_comb begin
    bcd_next = bcd;
    val_next = val;
    for (int b = 0; b < 4; b++) begin
      for (int d = 0; d < MAX_DIGITS; d++) begin
        if (bcd_next[4*d +: 4] >= 4'd5) bcd_next[4*d +: 4] = bcd_next[4*d +: 4] + 4'd3;
      end
      bcd_next = {bcd_next[DIGIT_BITS-2:0], val_next[PAD-1]};
      val_next = {val_next[PAD-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (res_valid && res_ready) res_valid <= 1'b0;
      if (take) begin
        if (q_hex) begin
          res_valid <= 1'b1;
        end else begin
          busy <= 1'b1;
        end
      end else if (busy && step == '0) begin
        busy      <= 1'b0;
        res_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      val     <= PAD'(q_value);
      bcd     <= '0;
      step    <= STEP_W'(NSTEP - 1);
      res.hex <= q_hex;
      // hex digits are the nibbles themselves
      if (q_hex) res.digits <= digits_t'(DIGIT_BITS'(q_value));
    end else if (busy) begin
      val  <= val_next;
      bcd  <= bcd_next;
      step <= step - 1'b1;
      if (step == '0) res.digits <= digits_t'(bcd_next);
    end
  end

endmodule
`default_nettype wire

// ----- rtl/gia_emit.sv -----
`timescale 1ns / 1ps
`default_nettype none
module gia_emit import gia_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      res_valid,
  output logic      res_ready,
  input  conv_res_t res,
  gia_chr_if.source chars
);

  logic       active;
  digits_t    digits;
  dcount_t    dleft;
  logic [1:0] gcnt;
  logic       comma_pend;
  logic       hex;
  dcount_t    nd;
  dcount_t    idx;
  logic       fire;
  logic       finish;
  logic       load;

  function automatic logic [1:0] idx_mask(input dcount_t n);
    dcount_t m;
    m = n - 4'd1;
    return m[1:0];
  endfunction

  assign idx            = dleft - 4'd1;
  assign chars.valid    = active;
  assign chars.out_char = comma_pend ? CH_COMMA : digit_char(digits[idx]);
  assign chars.last     = !comma_pend && (dleft == 4'd1);
  assign fire           = chars.valid && chars.ready;
  assign finish         = fire && chars.last;
  assign res_ready      = !active || finish;
  assign load           = res_valid && res_ready;

  // count of significant digits, at least one
  always_comb begin
    nd = 4'd1;
    for (int d = 1; d < MAX_DIGITS; d++) begin
      if (res.digits[d] != 4'd0) nd = dcount_t'(d + 1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active     <= 1'b0;
      comma_pend <= 1'b0;
    end else begin
      // a load while active only follows the last digit, so it replaces that fire
      if (load) begin
        active     <= 1'b1;
        comma_pend <= 1'b0;
        digits     <= res.digits;
        dleft      <= nd;
        hex        <= res.hex;
        gcnt       <= res.hex ? idx_mask(nd) : mod3(nd - 4'd1);
      end else if (fire) begin
        if (comma_pend) begin
          comma_pend <= 1'b0;
        end else if (dleft == 4'd1) begin
          active <= 1'b0;
        end else begin
          dleft <= dleft - 4'd1;
          // gcnt holds the digits after this one, mod the group size
          if (gcnt == 2'd0) begin
            comma_pend <= 1'b1;
            gcnt       <= hex ? HEX_GROUP_M1 : DEC_GROUP_M1;
          end else begin
            gcnt <= gcnt - 2'd1;
          end
        end
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/grouped_integer_to_ascii.sv -----
`timescale 1ns / 1ps
`default_nettype none
// channel  dir  handshake      payload
// num      in   valid/ready    value[31:0], hex_mode
// chars    out  valid/ready    out_char[7:0], last
//
// one character leaves per cycle while chars.ready is high and a number is
// being emitted; a number has at most 13 characters, commas included.
// the emitter can load the next number as the last character of the previous
// one leaves; decimal numbers first run through the shift-and-add-3 steps, hex
// ones skip them; a short number can leave idle cycles before the next one.
// a two-entry queue at the input takes requests while the back end stalls.
// rst is synchronous; everything is idle and empty the cycle after it.
module grouped_integer_to_ascii import gia_pkg::*; #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic      clk,
  input  logic      rst,
  gia_num_if.sink   num,
  gia_chr_if.source chars
);

  localparam int W_EFF = (VALUE_WIDTH < IN_WIDTH) ? VALUE_WIDTH : IN_WIDTH;

  logic             q_valid;
  logic             q_ready;
  logic [W_EFF-1:0] q_value;
  logic             q_hex;
  logic             res_valid;
  logic             res_ready;
  conv_res_t        res;

  gia_front #(.W_EFF(W_EFF)) u_front (
    .clk     (clk),
    .rst     (rst),
    .num     (num),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_value (q_value),
    .q_hex   (q_hex)
  );

  gia_conv #(.W_EFF(W_EFF)) u_conv (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_value   (q_value),
    .q_hex     (q_hex),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  gia_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .chars     (chars)
  );

endmodule
`default_nettype wire

// ----- rtl/gia_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "grouped_integer_to_ascii_defines.svh"
module gia_checker import gia_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       valid,
  input logic       ready,
  input logic [7:0] out_char,
  input logic       last
);

  logic is_digit;
  logic is_comma;

  assign is_comma = (out_char == CH_COMMA);
  assign is_digit = (out_char >= CH_ZERO && out_char <= CH_ZERO + 8'd9) ||
                    (out_char >= CH_A && out_char <= CH_A + 8'd5);

  `GIA_ASSERT_NEXT(a_hold, clk, rst, valid && !ready, valid && $stable(out_char) && $stable(last), "stalled character changed")
  `GIA_ASSERT_NOW(a_charset, clk, rst, valid, is_digit || is_comma, "character outside digit set")
  `GIA_ASSERT_NOW(a_comma_not_last, clk, rst, valid && is_comma, !last, "comma flagged as last")
  `GIA_ASSERT_NEXT(a_digit_after_comma, clk, rst, valid && ready && is_comma, valid && is_digit, "comma not followed by a digit")

endmodule

bind grouped_integer_to_ascii gia_checker u_gia_checker (
  .clk      (clk),
  .rst      (rst),
  .valid    (chars.valid),
  .ready    (chars.ready),
  .out_char (chars.out_char),
  .last     (chars.last)
);
`default_nettype wire

// ----- tb/grouped_integer_to_ascii_checker.sv -----
`timescale 1ns / 1ps
module gia_char_checker import gia_pkg::*; (
  input  logic clk,
  input  logic rst,
  gia_num_if   num,
  gia_chr_if   chars,
  output int   mismatches,
  output int   backlog,
  output int   numbers_seen,
  output int   chars_seen
);

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } glyph_t;

  glyph_t pending_chars[$];

  // lay out the characters of one number, most significant digit first
  function automatic void spell_number(input logic [31:0] v, input logic hex);
    logic [3:0]  digs [0:9];
    logic [31:0] base;
    logic [31:0] r;
    int          group;
    int          n;
    glyph_t      g;
    base  = hex ? 32'd16 : 32'd10;
    group = hex ? 4 : 3;
    r     = v;
    n     = 0;
    do begin
      digs[n] = 4'(r % base);
      r       = r / base;
      n++;
    end while (r != 0);
    for (int i = n - 1; i >= 0; i--) begin
      g.ch   = (digs[i] <= 4'd9) ? CH_ZERO + 8'(digs[i]) : CH_A + 8'(digs[i]) - 8'd10;
      g.last = (i == 0);
      pending_chars = {pending_chars, g};
      // comma once the digits still to come fill whole groups
      if (i != 0 && i % group == 0) begin
        g.ch   = CH_COMMA;
        g.last = 1'b0;
        pending_chars = {pending_chars, g};
      end
    end
  endfunction

  initial begin
    mismatches   = 0;
    backlog      = 0;
    numbers_seen = 0;
    chars_seen   = 0;
  end

  always @(posedge clk) begin
    glyph_t want;
    if (!rst) begin
      // new request goes in first, so a same-cycle character still meets older ones
      if (num.valid && num.ready) begin
        spell_number(num.value, num.hex_mode);
        numbers_seen++;
      end
      if (chars.valid && chars.ready) begin
        chars_seen++;
        if (pending_chars.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected character 0x%02h last %0b at %0t",
                     chars.out_char, chars.last, $realtime);
        end else begin
          want = pending_chars.pop_front();
          if (chars.out_char !== want.ch || chars.last !== want.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("char %0d: expected 0x%02h last %0b, got 0x%02h last %0b at %0t",
                       chars_seen, want.ch, want.last, chars.out_char, chars.last,
                       $realtime);
          end
        end
      end
      backlog = pending_chars.size();
    end
  end

endmodule

// ----- tb/grouped_integer_to_ascii_test.sv -----
`timescale 1ns / 1ps
module grouped_integer_to_ascii_test import gia_pkg::*;;

  localparam int CYCLE_LIMIT = 200000;

  logic clk = 1'b0;
  logic rst;
  int   cycles = 0;
  int   send_idle_pct;
  int   recv_idle_pct;
  int   mismatches;
  int   backlog;
  int   numbers_seen;
  int   chars_seen;

  gia_num_if num_bus ();
  gia_chr_if chr_bus ();

  grouped_integer_to_ascii u_dut (
    .clk   (clk),
    .rst   (rst),
    .num   (num_bus),
    .chars (chr_bus)
  );

  gia_char_checker u_chk (
    .clk          (clk),
    .rst          (rst),
    .num          (num_bus),
    .chars        (chr_bus),
    .mismatches   (mismatches),
    .backlog      (backlog),
    .numbers_seen (numbers_seen),
    .chars_seen   (chars_seen)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timed out after %0d cycles, %0d characters outstanding", cycles, backlog);
      $display("Test completed with failures");
      $finish;
    end
  end

  // receiver stalls
  initial begin
    chr_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      chr_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_number(input logic [31:0] v, input logic h);
    while ($urandom_range(99) < send_idle_pct) begin
      num_bus.valid    <= 1'b0;
      num_bus.value    <= $urandom;
      num_bus.hex_mode <= 1'($urandom_range(1));
      @(negedge clk);
    end
    num_bus.valid    <= 1'b1;
    num_bus.value    <= v;
    num_bus.hex_mode <= h;
    @(posedge clk);
    while (!num_bus.ready) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    logic [31:0] v;
    logic [31:0] p;
    logic        h;
    int          k;
    rst              = 1'b1;
    num_bus.valid    = 1'b0;
    num_bus.value    = '0;
    num_bus.hex_mode = 1'b0;
    send_idle_pct    = 19;
    recv_idle_pct    = 82;
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle_pct = 19; recv_idle_pct = 82; end
        1: begin send_idle_pct = 82; recv_idle_pct = 19; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      if (phase == 0) begin
        // zero, single digits, group boundaries and the top of the range
        send_number(32'd0, 1'b0);
        send_number(32'd0, 1'b1);
        send_number(32'd9, 1'b0);
        send_number(32'd10, 1'b0);
        send_number(32'd999, 1'b0);
        send_number(32'd1000, 1'b0);
        send_number(32'd999999, 1'b0);
        send_number(32'd1000000, 1'b0);
        send_number(32'd999999999, 1'b0);
        send_number(32'd1000000000, 1'b0);
        send_number(32'hffff_ffff, 1'b0);
        send_number(32'hffff_ffff, 1'b1);
        send_number(32'h0000_000f, 1'b1);
        send_number(32'h0000_0010, 1'b1);
        send_number(32'h0000_ffff, 1'b1);
        send_number(32'h0001_0000, 1'b1);
        send_number(32'h00ab_cdef, 1'b1);
        send_number(32'h1234_5678, 1'b1);
        send_number(32'h8000_0000, 1'b1);
        send_number(32'h8000_0000, 1'b0);
        send_number(32'd123456789, 1'b0);
        send_number(32'd12, 1'b1);
      end
      repeat (33) begin
        h = 1'($urandom_range(1));
        case ($urandom_range(4))
          0: v = $urandom;
          1: v = $urandom >> $urandom_range(31);
          2: v = 32'($urandom_range(9999));
          3: begin
            // a power of the base or one below it
            p = 32'd1;
            k = $urandom_range(h ? 7 : 9);
            repeat (k) p = p * (h ? 32'd16 : 32'd10);
            v = p - 32'($urandom_range(1));
          end
          default: v = 32'hffff_ffff >> $urandom_range(31);
        endcase
        send_number(v, h);
      end
      // stop offering the last request before draining
      num_bus.valid <= 1'b0;
      while (backlog != 0) @(negedge clk);
    end

    while (backlog != 0) @(negedge clk);
    repeat (40) @(negedge clk);

    $display("%0d numbers in decimal and hex, %0d characters checked", numbers_seen,
             chars_seen);
    $display("three stall patterns: slow receiver, slow sender, no stalls");
    if (mismatches == 0 && backlog == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches, %0d characters never arrived", mismatches, backlog);
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- grouped_integer_to_ascii.f -----
+incdir+rtl
rtl/gia_pkg.sv
rtl/gia_chan_if.sv
rtl/gia_front.sv
rtl/gia_conv.sv
rtl/gia_emit.sv
rtl/grouped_integer_to_ascii.sv
rtl/gia_checker.sv
tb/grouped_integer_to_ascii_checker.sv
tb/grouped_integer_to_ascii_test.sv
